/* hw/rtl/rarst_pkg.sv */
// Shared package of the range add / range sum tree block.
// Holds field widths, reset constants, the controller state type and the
// command and status structs between controller and datapath. No dependencies.
package rarst_pkg;

    localparam int VALUE_W          = 64;
    localparam int LEFT_W           = 10;
    localparam int RIGHT_W          = 11;
    localparam int SIZE_W           = 11;
    localparam int MAX_ELEMENTS_DEF = 1024;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_SUM = 1'b1;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_WALK  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic mul;
        logic walk;
        logic fin;
        logic clear;
        logic second;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic t_live;
        logic clr_last;
    } sts_t;

endpackage

/* hw/rtl/rarst_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on rarst_pkg for default sizes.
module rarst_ram #(
    parameter int WIDTH = rarst_pkg::VALUE_W,
    parameter int DEPTH = rarst_pkg::MAX_ELEMENTS_DEF + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/rarst_ctrl.sv */
// Controller state machine of the range add / range sum tree block.
// Sequences the clearing pass and the two tree walks of each transaction.
// Depends on rarst_pkg for the state type and the command and status structs.
module rarst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output rarst_pkg::cmd_t cmd,
    input  rarst_pkg::sts_t sts
);

    rarst_pkg::state_t state_reg, state_next;
    logic              second_reg, second_next;
    logic              done_reg, done_next;

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        done_next   = 1'b0;
        cmd         = '0;
        cmd.second  = second_reg;
        unique case (state_reg)
            rarst_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = rarst_pkg::ST_IDLE;
                end
            end
            rarst_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    second_next = 1'b0;
                    state_next  = rarst_pkg::ST_SETUP;
                end
            end
            rarst_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = sts.is_query ? rarst_pkg::ST_WALK : rarst_pkg::ST_MUL;
            end
            rarst_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = sts.is_query ? rarst_pkg::ST_FIN : rarst_pkg::ST_WALK;
            end
            rarst_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (!sts.t_live)
                begin
                    if (sts.is_query)
                    begin
                        state_next = rarst_pkg::ST_MUL;
                    end
                    else if (second_reg)
                    begin
                        state_next = rarst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        second_next = 1'b1;
                        state_next  = rarst_pkg::ST_SETUP;
                    end
                end
            end
            rarst_pkg::ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (second_reg)
                begin
                    done_next  = 1'b1;
                    state_next = rarst_pkg::ST_IDLE;
                end
                else
                begin
                    second_next = 1'b1;
                    state_next  = rarst_pkg::ST_SETUP;
                end
            end
            default:
            begin
                state_next = rarst_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rarst_pkg::ST_CLEAR;
            second_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            done_reg   <= done_next;
        end
    end

    assign busy = (state_reg != rarst_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

/* hw/rtl/rarst_dp.sv */
// Datapath of the range add / range sum tree block: the two tree memories,
// the walk index, the shared multiplier, the accumulators and the size register.
// Depends on rarst_pkg and rarst_ram.
module rarst_dp #(
    parameter int MAX_ELEMENTS = rarst_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rarst_pkg::cmd_t                     cmd,
    output rarst_pkg::sts_t                     sts,
    input  logic                                cfg_we,
    input  logic [rarst_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic                                action,
    input  logic [rarst_pkg::LEFT_W-1:0]        left_index,
    input  logic [rarst_pkg::RIGHT_W-1:0]       right_index,
    input  logic signed [rarst_pkg::VALUE_W-1:0] add_value,
    output logic signed [rarst_pkg::VALUE_W-1:0] range_sum
);

    localparam int VW = rarst_pkg::VALUE_W;
    localparam int AW = $clog2(MAX_ELEMENTS + 1);
    localparam int TW = (AW + 1 > rarst_pkg::RIGHT_W + 1) ? AW + 1 : rarst_pkg::RIGHT_W + 1;

    logic [rarst_pkg::SIZE_W-1:0]  active_size_reg;
    logic                          pend_reg;
    logic [AW-1:0]                 clr_reg;

    logic                          action_reg;
    logic [rarst_pkg::LEFT_W-1:0]  left_reg;
    logic [rarst_pkg::RIGHT_W-1:0] right_reg;
    logic [VW-1:0]                 value_reg;
    logic [VW-1:0]                 vsel_reg;
    logic [TW-1:0]                 pos_reg;
    logic [TW-1:0]                 t_reg;
    logic [AW-1:0]                 wb_addr_reg;
    logic [VW-1:0]                 mul_reg;
    logic [VW-1:0]                 acc1_reg;
    logic [VW-1:0]                 acc2_reg;
    logic [VW-1:0]                 total_reg;

    logic                          is_query;
    logic [TW-1:0]                 size_ext;
    logic [TW-1:0]                 max_ext;
    logic [TW-1:0]                 n_eff;
    logic                          sel_right;
    logic [TW-1:0]                 endpoint;
    logic [TW-1:0]                 k_clamp;
    logic [TW-1:0]                 lowbit;
    logic                          t_live;
    logic                          rd_en;
    logic [VW-1:0]                 mul_a;
    logic [VW+TW-1:0]              mul_full;
    logic [VW-1:0]                 fin_res;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [VW-1:0]                 d_wdata;
    logic [VW-1:0]                 w_wdata;
    logic [VW-1:0]                 d_rdata;
    logic [VW-1:0]                 w_rdata;

    assign is_query  = (action_reg == rarst_pkg::ACT_SUM);
    assign size_ext  = TW'(active_size_reg);
    assign max_ext   = TW'(MAX_ELEMENTS);
    assign n_eff     = (size_ext > max_ext) ? max_ext : size_ext;
    assign sel_right = is_query ? !cmd.second : cmd.second;
    assign endpoint  = sel_right ? TW'(right_reg) : TW'(left_reg);
    assign k_clamp   = (endpoint > n_eff) ? n_eff : endpoint;
    assign lowbit    = t_reg & (~t_reg + TW'(1));
    assign t_live    = (t_reg != '0) && (t_reg <= n_eff);
    assign rd_en     = cmd.walk && t_live;

    assign mul_a    = is_query ? acc1_reg : vsel_reg;
    assign mul_full = {{TW{1'b0}}, mul_a} * {{VW{1'b0}}, pos_reg};
    assign fin_res  = mul_reg - acc2_reg;

    assign ram_we    = cmd.clear || (pend_reg && !is_query);
    assign ram_waddr = cmd.clear ? clr_reg : wb_addr_reg;
    assign d_wdata   = cmd.clear ? '0 : d_rdata + vsel_reg;
    assign w_wdata   = cmd.clear ? '0 : w_rdata + mul_reg;

    assign sts.is_query = is_query;
    assign sts.t_live   = t_live;
    assign sts.clr_last = (clr_reg == AW'(MAX_ELEMENTS));

    assign range_sum = total_reg;

    rarst_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ELEMENTS + 1)
    ) u_delta_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (d_wdata),
        .re    (rd_en),
        .raddr (t_reg[AW-1:0]),
        .rdata (d_rdata)
    );

    rarst_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ELEMENTS + 1)
    ) u_weighted_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (w_wdata),
        .re    (rd_en),
        .raddr (t_reg[AW-1:0]),
        .rdata (w_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= rarst_pkg::SIZE_RESET;
            pend_reg        <= 1'b0;
            clr_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_size_reg <= cfg_wdata;
            end
            pend_reg <= rd_en;
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            left_reg   <= left_index;
            right_reg  <= right_index;
            value_reg  <= add_value;
        end
        if (cmd.setup)
        begin
            if (is_query)
            begin
                pos_reg <= k_clamp;
                t_reg   <= k_clamp;
            end
            else
            begin
                pos_reg <= endpoint;
                t_reg   <= endpoint + TW'(1);
            end
            vsel_reg <= cmd.second ? VW'(0) - value_reg : value_reg;
        end
        else if (rd_en)
        begin
            t_reg       <= is_query ? t_reg - lowbit : t_reg + lowbit;
            wb_addr_reg <= t_reg[AW-1:0];
        end
        if (cmd.setup)
        begin
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        else if (pend_reg && is_query)
        begin
            acc1_reg <= acc1_reg + d_rdata;
            acc2_reg <= acc2_reg + w_rdata;
        end
        if (cmd.mul)
        begin
            mul_reg <= mul_full[VW-1:0];
        end
        if (cmd.fin)
        begin
            total_reg <= cmd.second ? total_reg - fin_res : fin_res;
        end
    end

endmodule

/* hw/rtl/range_add_range_sum_tree.sv */
// Top level of the range add / range sum tree block.
// Depends on rarst_pkg, rarst_ctrl and rarst_dp.
//
// A transaction is accepted at a rising edge with start high and busy low.
// Action 0 adds add_value to every element in [left_index, right_index) and
// gives no result. Action 1 gives the sum over that range on range_sum,
// marked by done for exactly one cycle; the receiver cannot stall it.
// The array is held as two Fenwick trees in two memories that are walked in
// parallel, one tree entry per cycle through each memory's read port, with
// the write-back of an add in the cycle after its read.
// One tree path holds at most floor(log2(size)) + 1 entries, so 11 for 1024
// elements on an add path and 10 on a sum path. For each endpoint an add runs
// setup, multiply and walk, and a sum runs setup, walk, multiply and finish.
// One transaction is in work at a time.
// The size register is to be written with cfg_we and cfg_wdata only while the
// block is idle; the block itself does not enforce it. After reset, busy stays
// high while both memories are cleared one entry per cycle, 0 to MAX_ELEMENTS.
module range_add_range_sum_tree #(
    parameter int MAX_ELEMENTS = rarst_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 action,
    input  logic [rarst_pkg::LEFT_W-1:0]         left_index,
    input  logic [rarst_pkg::RIGHT_W-1:0]        right_index,
    input  logic signed [rarst_pkg::VALUE_W-1:0] add_value,
    output logic                                 done,
    output logic signed [rarst_pkg::VALUE_W-1:0] range_sum,
    input  logic                                 cfg_we,
    input  logic [rarst_pkg::SIZE_W-1:0]         cfg_wdata
);

    rarst_pkg::cmd_t cmd;
    rarst_pkg::sts_t sts;

    rarst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    rarst_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .action      (action),
        .left_index  (left_index),
        .right_index (right_index),
        .add_value   (add_value),
        .range_sum   (range_sum)
    );

endmodule

/* hw/rtl/rarst_chk.sv */
// Port-level checker of the range add / range sum tree block and its bind.
// Depends on rarst_pkg and on the ports of range_add_range_sum_tree.
module rarst_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic action,
    input logic done
);

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result is delivered only as the block returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a transaction");

    // The result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // An add transaction must not produce a result; done is checked at a single point after acceptance.
    a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == rarst_pkg::ACT_ADD) |=> ##1 !done)
        else $error("add transaction produced a result");

endmodule

bind range_add_range_sum_tree rarst_chk u_rarst_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .action (action),
    .done   (done)
);

/* sim/range_add_range_sum_tree_checker.sv */
// Checker of the range add / range sum tree block: watches the command,
// result and size-register channels, predicts every range sum and compares.
// Depends on rarst_pkg.
module range_add_range_sum_tree_checker
    import rarst_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        action,
    input  logic [LEFT_W-1:0]           left_index,
    input  logic [RIGHT_W-1:0]          right_index,
    input  logic signed [VALUE_W-1:0]   add_value,
    input  logic                        done,
    input  logic signed [VALUE_W-1:0]   range_sum,
    input  logic                        cfg_we,
    input  logic [SIZE_W-1:0]           cfg_wdata,
    output int                          fail_count,
    output int                          pending_sums
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [VALUE_W-1:0] count_tree [0:MAX_ELEMENTS];
    logic [VALUE_W-1:0] moment_tree [0:MAX_ELEMENTS];
    logic [SIZE_W-1:0]  size_reg;
    logic [VALUE_W-1:0] expected_sums [$];
    int                 mismatches = 0;
    int                 pending_q = 0;

    assign fail_count   = mismatches;
    assign pending_sums = pending_q;

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int unsigned walk_limit();
        return (size_reg > MAX_ELEMENTS) ? MAX_ELEMENTS : size_reg;
    endfunction

    task automatic scatter_diff(input int unsigned pos, input logic [VALUE_W-1:0] v);
        int unsigned        n;
        int unsigned        t;
        logic [VALUE_W-1:0] w;
        n = walk_limit();
        w = v * pos;
        t = pos + 1;
        while (t != 0 && t <= n)
        begin
            count_tree[t]  += v;
            moment_tree[t] += w;
            t += t & (~t + 1);
        end
    endtask

    function automatic logic [VALUE_W-1:0] prefix_total(input int unsigned k);
        int unsigned        n;
        int unsigned        t;
        logic [VALUE_W-1:0] s1;
        logic [VALUE_W-1:0] s2;
        n  = walk_limit();
        s1 = '0;
        s2 = '0;
        if (k > n)
            k = n;
        t = k;
        while (t != 0)
        begin
            s1 += count_tree[t];
            s2 += moment_tree[t];
            t -= t & (~t + 1);
        end
        return s1 * k - s2;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [VALUE_W-1:0] exp_sum;
        if (!rst_n)
        begin
            for (int unsigned i = 0; i <= MAX_ELEMENTS; i++)
            begin
                count_tree[i]  = '0;
                moment_tree[i] = '0;
            end
            size_reg = SIZE_RESET;
            expected_sums.delete();
            pending_q <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_sums.size() == 0)
                    report_mismatch($sformatf("result %0d with no transaction waiting",
                                              range_sum));
                else
                begin
                    exp_sum = expected_sums.pop_front();
                    if (range_sum !== exp_sum)
                        report_mismatch($sformatf("range_sum %0d, expected %0d",
                                                  range_sum, $signed(exp_sum)));
                end
            end
            if (start && !busy)
            begin
                if (action == ACT_SUM)
                    expected_sums.push_back(prefix_total(right_index) -
                                            prefix_total(left_index));
                else
                begin
                    scatter_diff(left_index, add_value);
                    scatter_diff(right_index, {VALUE_W{1'b0}} - add_value);
                end
            end
            if (cfg_we)
                size_reg = cfg_wdata;
            pending_q <= expected_sums.size();
        end
    end

endmodule

/* sim/range_add_range_sum_tree_tb.sv */
// Testbench top of the range add / range sum tree block: clock, reset,
// directed and random transactions, size-register writes and the verdict.
// Depends on rarst_pkg, range_add_range_sum_tree and its checker.
module range_add_range_sum_tree_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rarst_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 32;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      action = ACT_ADD;
    logic [LEFT_W-1:0]         left_index = '0;
    logic [RIGHT_W-1:0]        right_index = '0;
    logic signed [VALUE_W-1:0] add_value = '0;
    logic                      done;
    logic signed [VALUE_W-1:0] range_sum;
    logic                      cfg_we = 1'b0;
    logic [SIZE_W-1:0]         cfg_wdata = '0;
    int                        fail_count;
    int                        pending_sums;
    int                        cycle_count = 0;
    logic [SIZE_W-1:0]         cur_size = SIZE_RESET;

    range_add_range_sum_tree i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .left_index  (left_index),
        .right_index (right_index),
        .add_value   (add_value),
        .done        (done),
        .range_sum   (range_sum),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    range_add_range_sum_tree_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .left_index   (left_index),
        .right_index  (right_index),
        .add_value    (add_value),
        .done         (done),
        .range_sum    (range_sum),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending_sums (pending_sums)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL range_add_range_sum_tree");
            $finish;
        end
    end

    task automatic send(input logic act, input int unsigned l, input int unsigned r,
                        input logic [VALUE_W-1:0] v);
        start       <= 1'b1;
        action      <= act;
        left_index  <= l[LEFT_W-1:0];
        right_index <= r[RIGHT_W-1:0];
        add_value   <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_sums != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_size   = size;
        @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] x;
        case ($urandom_range(0, 5))
            0: x = {1'b1, {(VALUE_W-1){1'b0}}};
            1: x = {1'b0, {(VALUE_W-1){1'b1}}};
            2:
            begin
                x = $urandom_range(0, 200);
                x = x - 100;
            end
            default: x = {$urandom, $urandom};
        endcase
        return x;
    endfunction

    task automatic send_random(input bit quiet);
        int unsigned span;
        int unsigned l;
        int unsigned r;
        int unsigned tmp;
        int          kind;
        span = (cur_size == 0 || cur_size > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : cur_size;
        kind = $urandom_range(0, 9);
        l    = $urandom_range(0, span - 1);
        r    = $urandom_range(l + 1, span);
        if (kind == 7)
        begin
            tmp = l;
            l   = r;
            r   = tmp;
        end
        else if (kind == 8)
            r = l;
        else if (kind == 9)
        begin
            l = $urandom_range(0, MAX_ELEMENTS_DEF - 1);
            r = $urandom_range(0, (1 << RIGHT_W) - 1);
        end
        send($urandom_range(0, 1) ? ACT_SUM : ACT_ADD, l, r, pick_value());
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 11));
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] size, input int count, input bit quiet);
        write_size(size);
        repeat (count) send_random(quiet);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send(ACT_ADD, 0, 1024, 64'h7FFF_FFFF_FFFF_FFFF);
        send(ACT_SUM, 0, 1024, 64'h0000_0000_0000_1234);
        send(ACT_ADD, 0, 1, 64'h8000_0000_0000_0000);
        send(ACT_SUM, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF);
        idle_cycles(3);
        send(ACT_ADD, 1023, 1024, 64'hFFFF_FFFF_FFFF_FFFF);
        send(ACT_SUM, 1023, 1024, 64'd0);
        send(ACT_ADD, 5, 5, 64'd99);
        send(ACT_SUM, 5, 5, 64'd0);
        send(ACT_ADD, 10, 3, 64'd7);
        send(ACT_SUM, 20, 2, 64'd0);
        idle_cycles(7);
        send(ACT_ADD, 100, 2047, 64'd3);
        send(ACT_SUM, 50, 2047, 64'd0);
        send(ACT_ADD, 7, 8, 64'd1);
        send(ACT_SUM, 0, 500, 64'd0);
        send(ACT_SUM, 1023, 1024, 64'd0);
        send(ACT_ADD, 512, 513, 64'h5555_AAAA_5555_AAAA);
        send(ACT_SUM, 0, 1024, 64'd0);
        send(ACT_SUM, 1023, 0, 64'd0);

        run_phase(11'd1, 15, 1'b0);
        run_phase(11'd0, 12, 1'b0);
        run_phase(11'd2047, 50, 1'b0);
        run_phase(SIZE_W'($urandom_range(2, 1023)), 60, 1'b0);
        run_phase(11'd512, 40, 1'b0);
        settle();
        repeat (40) send_random(1'b0);
        run_phase(11'd3, 30, 1'b0);
        run_phase(SIZE_W'($urandom_range(1, 1024)), 60, 1'b0);
        run_phase(11'd1024, 100, 1'b1);
        settle();

        if (fail_count == 0 && pending_sums == 0)
            $display("PASS range_add_range_sum_tree");
        else
            $display("FAIL range_add_range_sum_tree");
        $finish;
    end

endmodule
